/* rtl/dgt_pkg.sv */
// Shared constants, action codes and controller states of the dirty granule tracker.
package dgt_pkg;

    localparam int ADDR_BITS_DEF     = 20;
    localparam int GRANULE_SHIFT_DEF = 6;
    localparam int MAP_WORD_BITS     = 8;
    localparam int BIT_SEL_BITS      = 3;

    typedef enum logic [1:0] {
        ACT_MARK  = 2'd0,
        ACT_QUERY = 2'd1,
        ACT_CLEAN = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_WALK  = 3'b100
    } state_t;

endpackage

/* rtl/dgt_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module dgt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/dgt_seq.sv */
// Bitmap sequencer: clearing pass, word walk with read-modify-write, and result register.
module dgt_seq
    import dgt_pkg::*;
#(
    parameter int WORD_AW = 11
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               go,
    input  action_t            op,
    input  logic               skip,
    input  logic [WORD_AW-1:0] first_word,
    input  logic [WORD_AW-1:0] last_word,
    input  logic [2:0]         first_bit,
    input  logic [2:0]         last_bit,
    output logic               busy,
    output logic               done,
    output logic               any_dirty
);

    localparam int DEPTH = 1 << WORD_AW;

    state_t                   state_reg, state_next;
    logic [WORD_AW-1:0]       clr_cnt_reg, clr_cnt_next;
    logic [WORD_AW-1:0]       word_reg, word_next;
    logic [WORD_AW-1:0]       last_word_reg, last_word_next;
    logic [2:0]               first_bit_reg, first_bit_next;
    logic [2:0]               last_bit_reg, last_bit_next;
    logic                     first_flag_reg, first_flag_next;
    action_t                  op_reg, op_next;
    logic                     done_reg, done_next;
    logic                     dirty_reg, dirty_next;

    logic                     ram_we;
    logic [WORD_AW-1:0]       ram_waddr;
    logic [MAP_WORD_BITS-1:0] ram_wdata;
    logic                     ram_re;
    logic [WORD_AW-1:0]       ram_raddr;
    logic [MAP_WORD_BITS-1:0] ram_rdata;

    logic [2:0]               lo_bit;
    logic [2:0]               hi_bit;
    logic [MAP_WORD_BITS-1:0] mask;
    logic                     at_last;
    logic                     hit;
    logic                     finish;

    dgt_ram #(
        .WIDTH (MAP_WORD_BITS),
        .DEPTH (DEPTH)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Bits of the current word that fall inside the granule range.
    always_comb
    begin
        at_last = (word_reg == last_word_reg);
        lo_bit  = first_flag_reg ? first_bit_reg : 3'd0;
        hi_bit  = at_last ? last_bit_reg : 3'd7;
        for (int i = 0; i < MAP_WORD_BITS; i++)
        begin
            mask[i] = (3'(i) >= lo_bit) && (3'(i) <= hi_bit);
        end
        hit    = |(ram_rdata & mask);
        finish = at_last || ((op_reg == ACT_QUERY) && hit);
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        word_next       = word_reg;
        last_word_next  = last_word_reg;
        first_bit_next  = first_bit_reg;
        last_bit_next   = last_bit_reg;
        first_flag_next = first_flag_reg;
        op_next         = op_reg;
        done_next       = 1'b0;
        dirty_next      = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = word_reg;
        ram_wdata       = '0;
        ram_re          = 1'b0;
        ram_raddr       = word_reg + 1'b1;

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == {WORD_AW{1'b1}})
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                // The first word is read in the accept cycle itself.
                ram_raddr = first_word;
                if (go)
                begin
                    if (skip)
                    begin
                        done_next = 1'b1;
                    end
                    else
                    begin
                        ram_re          = 1'b1;
                        state_next      = ST_WALK;
                        word_next       = first_word;
                        last_word_next  = last_word;
                        first_bit_next  = first_bit;
                        last_bit_next   = last_bit;
                        first_flag_next = 1'b1;
                        op_next         = op;
                    end
                end
            end
            ST_WALK:
            begin
                ram_we    = op_reg inside {ACT_MARK, ACT_CLEAN};
                ram_wdata = (op_reg == ACT_MARK) ? (ram_rdata | mask) : (ram_rdata & ~mask);
                if (finish)
                begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                    dirty_next = (op_reg == ACT_QUERY) && hit;
                end
                else
                begin
                    // Fetch the next word while this one is written back.
                    ram_re          = 1'b1;
                    word_next       = word_reg + 1'b1;
                    first_flag_next = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            done_reg    <= 1'b0;
            dirty_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            done_reg    <= done_next;
            dirty_reg   <= dirty_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg       <= word_next;
        last_word_reg  <= last_word_next;
        first_bit_reg  <= first_bit_next;
        last_bit_reg   <= last_bit_next;
        first_flag_reg <= first_flag_next;
        op_reg         <= op_next;
    end

    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign any_dirty = dirty_reg;

endmodule

/* rtl/code_dirty_granule_tracker_top.sv */
// Top level of the code dirty granule tracker: range decode and sequencer.
//
// The dirty bitmap holds one bit per granule of 2**GRANULE_SHIFT bytes, eight
// bits to a word of a single-port-read, single-port-write RAM. A transaction
// is accepted when start is high and busy is low; its result appears on
// any_dirty with done high for exactly one cycle and cannot be held off. A mark
// reads, modifies and writes back the single word holding its granule. A query
// or clean walks the bitmap words the range spans, the RAM delivering one
// word per cycle while the previous word is written back; a query stops at the
// first word holding a dirty granule. An empty query or clean, or an unused
// action, answers in the cycle after acceptance. After reset the block is busy
// while it clears all 2**(ADDR_BITS-GRANULE_SHIFT-3) bitmap words (2048 by
// default), one word per cycle. A new transaction may be accepted in the cycle
// its predecessor's result is shown.
module code_dirty_granule_tracker_top
    import dgt_pkg::*;
#(
    parameter int ADDR_BITS     = ADDR_BITS_DEF,
    parameter int GRANULE_SHIFT = GRANULE_SHIFT_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           action,
    input  logic [ADDR_BITS-1:0] base_addr,
    input  logic [ADDR_BITS:0]   limit_addr,
    output logic                 done,
    output logic                 any_dirty
);

    localparam int GRAN_W  = ADDR_BITS - GRANULE_SHIFT;
    localparam int WORD_AW = GRAN_W - BIT_SEL_BITS;

    action_t              op;
    logic [ADDR_BITS:0]   mem_bytes;
    logic [ADDR_BITS:0]   end_sat;
    logic [ADDR_BITS:0]   end_m1;
    logic                 empty;
    logic                 skip;
    logic [GRAN_W-1:0]    first_g;
    logic [GRAN_W-1:0]    last_g;

    always_comb
    begin
        op        = action_t'(action);
        mem_bytes = {1'b1, {ADDR_BITS{1'b0}}};
        // An end beyond the memory saturates to the memory size.
        end_sat   = limit_addr[ADDR_BITS] ? mem_bytes : limit_addr;
        empty     = ({1'b0, base_addr} >= end_sat);
        end_m1    = end_sat - 1'b1;
        first_g   = base_addr[ADDR_BITS-1:GRANULE_SHIFT];
        last_g    = (op == ACT_MARK) ? first_g : end_m1[ADDR_BITS-1:GRANULE_SHIFT];
        skip      = (op == ACT_NONE) || (empty && (op != ACT_MARK));
    end

    dgt_seq #(
        .WORD_AW (WORD_AW)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .go         (start && !busy),
        .op         (op),
        .skip       (skip),
        .first_word (first_g[GRAN_W-1:BIT_SEL_BITS]),
        .last_word  (last_g[GRAN_W-1:BIT_SEL_BITS]),
        .first_bit  (first_g[BIT_SEL_BITS-1:0]),
        .last_bit   (last_g[BIT_SEL_BITS-1:0]),
        .busy       (busy),
        .done       (done),
        .any_dirty  (any_dirty)
    );

endmodule

/* rtl/dgt_checker.sv */
// Port-level checker for the dirty granule tracker, bound to the top level.
module dgt_checker
    import dgt_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] action,
    input logic       done,
    input logic       any_dirty
);

    // A dirty answer is only ever shown with its strobe.
    a_dirty_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        any_dirty |-> done)
        else $error("any_dirty high without done");

    // A mark is a single read-modify-write and answers with done and any_dirty low.
    a_mark_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (action == ACT_MARK)) |-> ##2 (done && !any_dirty))
        else $error("mark transaction did not complete in two cycles");

    // An unused action answers clean in the next cycle.
    a_none_answer: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (action == ACT_NONE)) |=> (done && !any_dirty && !busy))
        else $error("unused action not answered at once");

    // An accepted transaction either starts a walk or answers immediately.
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted transaction was dropped");

endmodule

bind code_dirty_granule_tracker_top dgt_checker u_dgt_checker (.*);

/* tb/code_dirty_granule_tracker_top_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the code dirty granule tracker: directed table, then random traffic.
module code_dirty_granule_tracker_top_test;
    import dgt_pkg::*;

    localparam int MEM_BYTES     = 1 << ADDR_BITS_DEF;
    localparam int GRANULE_COUNT = MEM_BYTES >> GRANULE_SHIFT_DEF;
    localparam int RANDOM_ITEMS  = 1850;
    localparam int MAX_GAP       = 12;

    typedef struct {
        action_t                act;
        logic [ADDR_BITS_DEF-1:0] saddr;
        logic [ADDR_BITS_DEF:0]   eaddr;
        bit                     typed;
        bit                     typed_value;
    } stim_row_t;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic [1:0]               action;
    logic [ADDR_BITS_DEF-1:0] base_addr;
    logic [ADDR_BITS_DEF:0]   limit_addr;
    logic                     done;
    logic                     any_dirty;

    // Travel alongside the fields so the monitor sees them at the accepting edge.
    bit row_typed;
    bit row_typed_value;

    bit        granule_dirty [0:GRANULE_COUNT-1];
    bit        any_dirty_expect_q [$];
    stim_row_t directed_rows [$];
    int        mismatch_count;
    bit        steady_sender;

    code_dirty_granule_tracker_top DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .action     (action),
        .base_addr  (base_addr),
        .limit_addr (limit_addr),
        .done       (done),
        .any_dirty  (any_dirty)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // Applies one transaction to the shadow bitmap and returns the answer it should give.
    function automatic bit apply_to_dirty_map(action_t act, logic [ADDR_BITS_DEF-1:0] saddr,
                                              logic [ADDR_BITS_DEF:0] eaddr);
        int unsigned end_byte;
        int unsigned first_g;
        int unsigned last_g;
        bit          hit;
        hit = 1'b0;
        end_byte = (eaddr > MEM_BYTES) ? MEM_BYTES : eaddr;
        case (act)
            ACT_MARK:
                granule_dirty[saddr >> GRANULE_SHIFT_DEF] = 1'b1;
            ACT_QUERY, ACT_CLEAN:
                if (saddr < end_byte)
                begin
                    first_g = saddr >> GRANULE_SHIFT_DEF;
                    last_g  = (end_byte - 1) >> GRANULE_SHIFT_DEF;
                    for (int unsigned g = first_g; g <= last_g; g++)
                    begin
                        if (act == ACT_QUERY)
                            hit |= granule_dirty[g];
                        else
                            granule_dirty[g] = 1'b0;
                    end
                end
            default:
                ;
        endcase
        return hit;
    endfunction

    always @(posedge clk)
    begin : result_monitor
        bit wanted;
        bit predicted;
        if (rst_n)
        begin
            if (done)
            begin
                if (any_dirty_expect_q.size() == 0)
                begin
                    $display("%0t: result with none pending: expected none, actual any_dirty=%0b",
                             $time, any_dirty);
                    mismatch_count++;
                end
                else
                begin
                    wanted = any_dirty_expect_q.pop_front();
                    if (any_dirty !== wanted)
                    begin
                        $display("%0t: any_dirty mismatch: expected %0b, actual %0b",
                                 $time, wanted, any_dirty);
                        mismatch_count++;
                    end
                end
            end
            if (start && !busy)
            begin
                predicted = apply_to_dirty_map(action_t'(action), base_addr, limit_addr);
                any_dirty_expect_q.push_back(row_typed ? row_typed_value : predicted);
            end
        end
    end

    // Drives one transaction after a random idle gap and returns at the edge that accepts it.
    task automatic issue_transaction(input action_t act, input logic [ADDR_BITS_DEF-1:0] saddr,
                                     input logic [ADDR_BITS_DEF:0] eaddr, input bit typed,
                                     input bit typed_value);
        int gap;
        gap = 0;
        if (!steady_sender)
            while (gap < MAX_GAP && $urandom_range(0, 99) < 34)
                gap++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start           <= 1'b1;
        action          <= act;
        base_addr       <= saddr;
        limit_addr      <= eaddr;
        row_typed       <= typed;
        row_typed_value <= typed_value;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic add_row(input action_t act, input int unsigned saddr, input int unsigned eaddr,
                           input bit typed, input bit typed_value);
        directed_rows.push_back('{act, saddr[ADDR_BITS_DEF-1:0], eaddr[ADDR_BITS_DEF:0],
                                  typed, typed_value});
    endtask

    initial
    begin
        #200ms;
        $display("** code_dirty_granule_tracker_top: FAILED **");
        $finish;
    end

    initial
    begin : stimulus
        action_t                  act;
        logic [ADDR_BITS_DEF-1:0] hot_base;
        logic [ADDR_BITS_DEF-1:0] saddr;
        int unsigned              eaddr;
        int unsigned              pick;
        int unsigned              span;

        rst_n           = 1'b0;
        start           = 1'b0;
        action          = ACT_MARK;
        base_addr       = '0;
        limit_addr      = '0;
        row_typed       = 1'b0;
        row_typed_value = 1'b0;
        mismatch_count  = 0;
        steady_sender   = 1'b0;
        hot_base        = '0;

        // Columns: action, start, end, answer typed in, typed answer.
        add_row(ACT_QUERY, 20'h00000, 21'h100000, 1'b1, 1'b0);  // whole map clean after reset
        add_row(ACT_MARK,  20'h00000, 21'h000000, 1'b1, 1'b0);
        add_row(ACT_QUERY, 20'h00000, 21'h000001, 1'b1, 1'b1);
        add_row(ACT_MARK,  20'hFFFFF, 21'h1FFFFF, 1'b1, 1'b0);  // top byte of memory
        add_row(ACT_QUERY, 20'hFFFC0, 21'h100000, 1'b1, 1'b1);
        add_row(ACT_QUERY, 20'h00005, 21'h000005, 1'b1, 1'b0);  // empty range
        add_row(ACT_QUERY, 20'h00064, 21'h000032, 1'b1, 1'b0);  // inverted range
        add_row(ACT_NONE,  20'hFFFFF, 21'h1FFFFF, 1'b1, 1'b0);  // unused action
        add_row(ACT_QUERY, 20'hFFFFF, 21'h000000, 1'b1, 1'b0);
        add_row(ACT_MARK,  20'h001C0, 21'h000000, 1'b0, 1'b0);  // last granule of word 0
        add_row(ACT_QUERY, 20'h00200, 21'h000400, 1'b0, 1'b0);
        add_row(ACT_QUERY, 20'h001FF, 21'h000201, 1'b0, 1'b0);  // crosses a word boundary
        add_row(ACT_CLEAN, 20'h00000, 21'h000040, 1'b1, 1'b0);
        add_row(ACT_QUERY, 20'h00000, 21'h000040, 1'b0, 1'b0);
        add_row(ACT_CLEAN, 20'h001C0, 21'h0001C0, 1'b1, 1'b0);  // empty clean is a no-op
        add_row(ACT_QUERY, 20'h001C0, 21'h000200, 1'b0, 1'b0);
        add_row(ACT_QUERY, 20'hFFFFF, 21'h1FFFFF, 1'b1, 1'b1);  // end saturates to memory size
        add_row(ACT_CLEAN, 20'hFFFC0, 21'h1FFFFF, 1'b1, 1'b0);
        add_row(ACT_QUERY, 20'h80000, 21'h1FFFFF, 1'b0, 1'b0);
        add_row(ACT_CLEAN, 20'h00000, 21'h100000, 1'b1, 1'b0);
        add_row(ACT_QUERY, 20'h00000, 21'h1FFFFF, 1'b1, 1'b0);
        add_row(ACT_MARK,  20'hAAAAA, 21'h155555, 1'b0, 1'b0);
        add_row(ACT_QUERY, 20'h55555, 21'h155555, 1'b0, 1'b0);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            issue_transaction(directed_rows[i].act, directed_rows[i].saddr,
                              directed_rows[i].eaddr, directed_rows[i].typed,
                              directed_rows[i].typed_value);

        // Most traffic stays inside a moving 4 KB window so that marks, queries and
        // cleans overlap; a few ranges sweep nearly the whole map.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            steady_sender = (n >= 600 && n < 900);
            if (n % 64 == 0)
                hot_base = ADDR_BITS_DEF'($urandom_range(0, MEM_BYTES - 1));
            saddr = ADDR_BITS_DEF'(hot_base + $urandom_range(0, 4095));
            pick = $urandom_range(0, 99);
            if (pick < 40)
                act = ACT_MARK;
            else if (pick < 75)
                act = ACT_QUERY;
            else if (pick < 95)
                act = ACT_CLEAN;
            else
                act = ACT_NONE;

            pick = $urandom_range(0, 99);
            if (act == ACT_MARK && pick < 10)
                saddr = ADDR_BITS_DEF'($urandom_range(0, MEM_BYTES - 1));
            if (pick < 4)
            begin
                span  = $urandom_range(0, 64);
                eaddr = (saddr >= span) ? saddr - span : 0;
            end
            else if (pick < 6)
            begin
                saddr = ADDR_BITS_DEF'($urandom_range(0, 4095));
                eaddr = $urandom_range(32'h0F0000, 32'h1FFFFF);
            end
            else if (pick < 20)
                eaddr = saddr + $urandom_range(1, 32768);
            else
                eaddr = saddr + $urandom_range(1, 1024);

            issue_transaction(act, saddr, eaddr[ADDR_BITS_DEF:0], 1'b0, 1'b0);
        end
        start <= 1'b0;

        while (any_dirty_expect_q.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        if (mismatch_count == 0)
            $display("** code_dirty_granule_tracker_top: PASSED **");
        else
            $display("** code_dirty_granule_tracker_top: FAILED **");
        $finish;
    end

endmodule

/* sim.f */
rtl/dgt_pkg.sv
rtl/dgt_ram.sv
rtl/dgt_seq.sv
rtl/code_dirty_granule_tracker_top.sv
rtl/dgt_checker.sv
tb/code_dirty_granule_tracker_top_test.sv
